>>> rtl/core/thsum_pkg.sv
// ----------------------------------------------------------------------------
// thsum_pkg
// Shared constants, types and helpers for the thermistor frame summary.
// ----------------------------------------------------------------------------
package thsum_pkg;

    localparam int SENSOR_COUNT  = 6;       // samples per frame, 1..16
    localparam int TEMP_W        = 12;      // signed, 4 fraction bits
    localparam int POS_W         = 4;
    localparam int SUM_W         = 16;
    localparam int MAG_W         = SUM_W + 1;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 56;

    localparam logic [7:0] CHECKSUM_SEED = 8'h41;

    // average = sum / (16 * SENSOR_COUNT); done as |sum| * ceil(2^K / D) >> K,
    // exact for |sum| < 2^16 since the rounding error stays below 2^(K-16)
    localparam int DIVISOR     = 16 * SENSOR_COUNT;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int RECIP_W     = $clog2(RECIP_MULT + 1);
    localparam int PROD_W      = MAG_W + RECIP_W;

    localparam logic [POS_W-1:0] LAST_POS     = POS_W'(SENSOR_COUNT - 1);
    localparam logic [4:0]       SENSOR_TOTAL = 5'(SENSOR_COUNT);

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [2:0]        pad;
        logic [7:0]        frame_checksum;
        logic [3:0]        low_sensor;
        logic [3:0]        high_sensor;
        logic [4:0]        sensor_total;
        logic signed [7:0] average_value;
        logic signed [7:0] high_value;
        logic signed [7:0] low_value;
        logic [7:0]        module_id;
    } summary_t;

    // integer degrees, truncated toward zero
    function automatic logic signed [7:0] whole_degrees(input logic signed [TEMP_W-1:0] t);
        logic signed [7:0] q;
        q = t[TEMP_W-1:4];
        if (t[TEMP_W-1] && (t[3:0] != 4'd0)) begin
            q = q + 8'sd1;
        end
        return q;
    endfunction

endpackage

>>> rtl/core/thermistor_min_max_avg_summary.sv
// ----------------------------------------------------------------------------
// thermistor_min_max_avg_summary
// Per-frame low/high/average of thermistor samples with sensor indices and
// a byte checksum, one summary word per frame.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata[11:0] temperature
//  m_      | out       | m_tvalid/m_tready  | m_tdata[52:0] summary record
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_data[7:0] module number
//
//  One sample per cycle unless a stall holds s_tready low. After the last
//  sample of a frame, its summary passes the input reg, frame reg, divide
//  product reg and output reg. Reset clears the valid bits and frame position.
//  A stall on m_ backs up through the stages; s_tready drops only when the
//  stage ahead of a frame's last sample is full.
// ----------------------------------------------------------------------------
module thermistor_min_max_avg_summary (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [thsum_pkg::S_TDATA_W-1:0]  s_tdata,   // [11:0] temperature
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] module_id, [15:8] low_value, [23:16] high_value,
    // [31:24] average_value, [36:32] sensor_total, [40:37] high_sensor,
    // [44:41] low_sensor, [52:45] frame_checksum
    output logic [thsum_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [7:0]                       cfg_data
);
    import thsum_pkg::*;

    logic [7:0]               module_number_reg;

    logic                     in_valid_reg;
    logic signed [TEMP_W-1:0] in_temp_reg;

    logic [POS_W-1:0]         pos_reg;
    logic signed [7:0]        run_low_reg, run_high_reg;
    logic [3:0]               run_low_idx_reg, run_high_idx_reg;
    logic signed [SUM_W-1:0]  run_sum_reg;

    logic                     f_valid_reg;
    logic signed [7:0]        f_low_reg, f_high_reg;
    logic [3:0]               f_low_idx_reg, f_high_idx_reg;
    logic signed [SUM_W-1:0]  f_sum_reg;

    logic                     p_valid_reg;
    logic                     p_neg_reg;
    logic [PROD_W-1:0]        p_prod_reg;
    logic signed [7:0]        p_low_reg, p_high_reg;
    logic [3:0]               p_low_idx_reg, p_high_idx_reg;

    logic                     m_tvalid_reg;
    summary_t                 m_data_reg;

    logic                     out_free, p_free, f_free;
    logic                     p_adv, f_adv, s0_adv, is_last, first;
    logic signed [7:0]        whole;
    logic signed [SUM_W-1:0]  sample_ext;

    logic signed [7:0]        low_next, high_next;
    logic [3:0]               low_idx_next, high_idx_next;
    logic signed [SUM_W-1:0]  sum_next;
    logic [POS_W-1:0]         pos_next;

    logic [MAG_W-1:0]         f_mag;
    logic [7:0]               quot;
    summary_t                 rec_next;

    // ---------------- stage flow ----------------
    assign out_free  = !m_tvalid_reg || m_tready;
    assign p_adv     = p_valid_reg && out_free;
    assign p_free    = !p_valid_reg || out_free;
    assign f_adv     = f_valid_reg && p_free;
    assign f_free    = !f_valid_reg || p_free;
    assign is_last   = (pos_reg == LAST_POS);
    assign s0_adv    = in_valid_reg && (!is_last || f_free);
    assign s_tready  = !in_valid_reg || s0_adv;
    assign cfg_ready = 1'b1;

    // ---------------- running update ----------------
    assign whole      = whole_degrees(in_temp_reg);
    assign sample_ext = SUM_W'(in_temp_reg);
    assign first      = (pos_reg == '0);

    always_comb begin
        low_next      = run_low_reg;
        high_next     = run_high_reg;
        low_idx_next  = run_low_idx_reg;
        high_idx_next = run_high_idx_reg;
        if (first) begin
            low_next      = whole;
            high_next     = whole;
            low_idx_next  = '0;
            high_idx_next = '0;
            sum_next      = sample_ext;
        end else begin
            sum_next = run_sum_reg + sample_ext;
            if (whole < run_low_reg) begin
                low_next     = whole;
                low_idx_next = pos_reg;
            end
            if (whole > run_high_reg) begin
                high_next     = whole;
                high_idx_next = pos_reg;
            end
        end
        pos_next = is_last ? '0 : pos_reg + POS_W'(1);
    end

    // ---------------- divide and record ----------------
    assign f_mag = f_sum_reg[SUM_W-1] ? MAG_W'(-{f_sum_reg[SUM_W-1], f_sum_reg})
                                      : {1'b0, f_sum_reg};
    assign quot  = p_prod_reg[RECIP_SHIFT +: 8];

    always_comb begin
        rec_next                = '0;
        rec_next.module_id      = module_number_reg;
        rec_next.low_value      = p_low_reg;
        rec_next.high_value     = p_high_reg;
        rec_next.average_value  = p_neg_reg ? 8'(-quot) : quot;
        rec_next.sensor_total   = SENSOR_TOTAL;
        rec_next.high_sensor    = p_high_idx_reg;
        rec_next.low_sensor     = p_low_idx_reg;
        rec_next.frame_checksum = rec_next.module_id + rec_next.low_value
                                + rec_next.high_value + rec_next.average_value
                                + {3'd0, rec_next.sensor_total}
                                + {4'd0, rec_next.high_sensor}
                                + {4'd0, rec_next.low_sensor} + CHECKSUM_SEED;
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            module_number_reg <= '0;
            in_valid_reg      <= 1'b0;
            pos_reg           <= '0;
            f_valid_reg       <= 1'b0;
            p_valid_reg       <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                module_number_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (s0_adv) begin
                pos_reg <= pos_next;
            end
            if (s0_adv && is_last) begin
                f_valid_reg <= 1'b1;
            end else if (f_adv) begin
                f_valid_reg <= 1'b0;
            end
            if (p_free) begin
                p_valid_reg <= f_valid_reg;
            end
            if (out_free) begin
                m_tvalid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_temp_reg <= s_tdata[TEMP_W-1:0];
        end
        if (s0_adv) begin
            run_low_reg      <= low_next;
            run_high_reg     <= high_next;
            run_low_idx_reg  <= low_idx_next;
            run_high_idx_reg <= high_idx_next;
            run_sum_reg      <= sum_next;
        end
        if (s0_adv && is_last) begin
            f_low_reg      <= low_next;
            f_high_reg     <= high_next;
            f_low_idx_reg  <= low_idx_next;
            f_high_idx_reg <= high_idx_next;
            f_sum_reg      <= sum_next;
        end
        if (f_adv) begin
            p_prod_reg     <= PROD_W'(f_mag) * PROD_W'(RECIP_MULT);
            p_neg_reg      <= f_sum_reg[SUM_W-1];
            p_low_reg      <= f_low_reg;
            p_high_reg     <= f_high_reg;
            p_low_idx_reg  <= f_low_idx_reg;
            p_high_idx_reg <= f_high_idx_reg;
        end
        if (p_adv) begin
            m_data_reg <= rec_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- checks ----------------
    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LAST_POS)
        else $error("frame position past last sensor");

    a_low_le_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_data_reg.low_value <= m_data_reg.high_value))
        else $error("summary low above high");

    // truncation is monotonic, so the average stays within low..high
    a_avg_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_data_reg.average_value >= m_data_reg.low_value
                          && m_data_reg.average_value <= m_data_reg.high_value))
        else $error("summary average outside low/high");

    a_checksum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_data_reg.frame_checksum ==
            8'(m_data_reg.module_id + m_data_reg.low_value + m_data_reg.high_value
               + m_data_reg.average_value + {3'd0, m_data_reg.sensor_total}
               + {4'd0, m_data_reg.high_sensor} + {4'd0, m_data_reg.low_sensor}
               + CHECKSUM_SEED)))
        else $error("summary checksum mismatch");

endmodule
